### src/gcbn_pkg.sv
// Shared types and constants for the grid cell binning and neighbour block.
// No dependencies; every other file in src imports this package.
package gcbn_pkg;

   localparam int POS_W       = 24;   // signed Q15.8 position and origin
   localparam int IDX_W       = 20;   // row-major cell index
   localparam int SIZE_W      = 11;   // grid_columns and grid_rows registers
   localparam int SHIFT_W     = 5;    // cell_shift register
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam int DEF_MAX_COLUMNS = 1024;
   localparam int DEF_MAX_ROWS    = 1024;
   localparam int QUEUE_DEPTH     = 2;

   // Neighbour slots of the 3x3 block, numbered (dr + 1) * 3 + (dc + 1).
   localparam int SLOT_COUNT = 9;
   localparam int SLOT_SELF  = 4;

   localparam logic [SIZE_W-1:0]  RST_COLUMNS = 11'd64;
   localparam logic [SIZE_W-1:0]  RST_ROWS    = 11'd64;
   localparam logic [SHIFT_W-1:0] RST_SHIFT   = 5'd8;

   typedef enum logic [1:0] {
      MODE_BIN  = 2'd0,
      MODE_FWD  = 2'd1,
      MODE_ALL  = 2'd2,
      MODE_SKIP = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_COLUMNS    = 3'd0,
      REG_ROWS       = 3'd1,
      REG_ORIGIN_X   = 3'd2,
      REG_ORIGIN_Y   = 3'd3,
      REG_CELL_SHIFT = 3'd4
   } csr_reg_type;

   typedef struct packed {
      mode_type                 mode;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic [IDX_W-1:0]         centre_cell;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] cell_index;
      logic             in_grid;
      logic             is_last;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0]        grid_columns;
      logic [SIZE_W-1:0]        grid_rows;
      logic signed [POS_W-1:0]  origin_x;
      logic signed [POS_W-1:0]  origin_y;
      logic [SHIFT_W-1:0]       cell_shift;
   } cfg_type;

   // One classified request as handed from the front end to the back end.
   typedef struct packed {
      logic [IDX_W-1:0]      base;
      logic                  in_grid;
      logic [SLOT_COUNT-1:0] mask;
   } work_type;

endpackage

### src/gcbn_front.sv
// Front end: accepts requests, bins positions and splits centre cells into
// row and column with an iterative divider. Depends on gcbn_pkg.
module gcbn_front #(
   parameter int MAX_COLUMNS = gcbn_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = gcbn_pkg::DEF_MAX_ROWS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gcbn_pkg::cfg_type                    cfg,
   input  logic                                 push,
   output logic                                 full,
   input  gcbn_pkg::req_type                    req_data,
   input  logic                                 wq_full,
   output logic                                 wq_push,
   output gcbn_pkg::work_type                   wq_data,
   output logic [$clog2(MAX_COLUMNS + 1)-1:0]   cols_eff
);
   import gcbn_pkg::*;

   localparam int CW    = $clog2(MAX_COLUMNS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int QW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int STEPS = (QW + 1) / 2;
   localparam int QP    = 2 * STEPS;
   localparam int DW    = CW + QP;
   localparam int MW    = (DW > IDX_W) ? DW : IDX_W;
   localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int AW    = CW + RW;
   localparam int PW    = POS_W + 1;
   localparam int PRW   = RW + CW;
   localparam logic [SLOT_COUNT-1:0] FWD_SLOTS = 9'b1_1111_0000;
   localparam logic [SLOT_COUNT-1:0] SELF_ONLY = SLOT_COUNT'(1) << SLOT_SELF;

   function automatic logic [SLOT_COUNT-1:0] nbr_mask(input logic r_lo, input logic r_hi,
                                                      input logic c_lo, input logic c_hi);
      logic [2:0]            rv;
      logic [2:0]            cv;
      logic [SLOT_COUNT-1:0] m;
      rv = {r_hi, 1'b1, r_lo};
      cv = {c_hi, 1'b1, c_lo};
      for (int dr = 0; dr < 3; dr++) begin
         for (int dc = 0; dc < 3; dc++) begin
            m[dr * 3 + dc] = rv[dr] & cv[dc];
         end
      end
      return m;
   endfunction

   // Effective grid size, with zero taken as one and large values clamped.
   logic [CW-1:0] cols_c;
   logic [RW-1:0] rows_c;

   always_comb begin
      if (cfg.grid_columns == '0) begin
         cols_c = CW'(1);
      end else if (32'(cfg.grid_columns) > MAX_COLUMNS) begin
         cols_c = CW'(MAX_COLUMNS);
      end else begin
         cols_c = CW'(cfg.grid_columns);
      end
      if (cfg.grid_rows == '0) begin
         rows_c = RW'(1);
      end else if (32'(cfg.grid_rows) > MAX_ROWS) begin
         rows_c = RW'(MAX_ROWS);
      end else begin
         rows_c = RW'(cfg.grid_rows);
      end
   end

   logic [CW-1:0] cols_ff;
   logic [RW-1:0] rows_ff;
   logic [AW-1:0] area_ff, area_in;

   assign area_in  = AW'(cols_c) * AW'(rows_c);
   assign cols_eff = cols_ff;

   // Input stage and divider state.
   logic             s1_valid_ff, s1_valid_in;
   req_type          s1_ff;
   logic [MW-1:0]    rem_ff, rem_in;
   logic [MW-1:0]    dv_ff, dv_in;
   logic [QP-1:0]    quo_ff, quo_in;
   logic [SCW-1:0]   cnt_ff, cnt_in;
   logic             done_ff, done_in;

   // Classified stage ahead of the queue.
   logic             s2_valid_ff, s2_valid_in;
   mode_type         s2_mode_ff, s2_mode_in;
   logic             s2_ok_ff, s2_ok_in;
   logic [RW-1:0]    s2_row_ff, s2_row_in;
   logic [CW-1:0]    s2_col_ff, s2_col_in;
   logic [IDX_W-1:0] s2_centre_ff, s2_centre_in;

   logic                 accept, s1_go, s2_free, s2_load;
   logic                 is_nbr, centre_in, need_div, div_step;
   logic signed [PW-1:0] dx, dy, col_s, row_s;
   logic                 bin_ok;
   logic                 b1, b0;
   logic [MW-1:0]        t1, t0, dv_half;

   // Binning: exact floor of the offset from the origin by 2^cell_shift.
   always_comb begin
      dx     = {s1_ff.pos_x[POS_W-1], s1_ff.pos_x} - {cfg.origin_x[POS_W-1], cfg.origin_x};
      dy     = {s1_ff.pos_y[POS_W-1], s1_ff.pos_y} - {cfg.origin_y[POS_W-1], cfg.origin_y};
      col_s  = dx >>> cfg.cell_shift;
      row_s  = dy >>> cfg.cell_shift;
      bin_ok = !col_s[PW-1] && ($unsigned(col_s) < PW'(cols_ff)) &&
               !row_s[PW-1] && ($unsigned(row_s) < PW'(rows_ff));
   end

   always_comb begin
      is_nbr    = (s1_ff.mode == MODE_FWD) || (s1_ff.mode == MODE_ALL);
      centre_in = 32'(s1_ff.centre_cell) < 32'(area_ff);
      need_div  = is_nbr && centre_in;
      s2_free   = !s2_valid_ff || !wq_full;
      s1_go     = s1_valid_ff && (!need_div || done_ff) && s2_free;
      s2_load   = s1_go && (s1_ff.mode != MODE_SKIP);
      full      = s1_valid_ff && !s1_go;
      accept    = push && !full;
      div_step  = s1_valid_ff && need_div && !done_ff;
   end

   // Two restoring division steps per cycle.
   always_comb begin
      dv_half = dv_ff >> 1;
      b1      = rem_ff >= dv_ff;
      t1      = b1 ? (rem_ff - dv_ff) : rem_ff;
      b0      = t1 >= dv_half;
      t0      = b0 ? (t1 - dv_half) : t1;
   end

   always_comb begin
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (accept) begin
         rem_in  = MW'(req_data.centre_cell);
         dv_in   = MW'(cols_c) << (QP - 1);
         quo_in  = '0;
         cnt_in  = '0;
         done_in = 1'b0;
      end else if (div_step) begin
         rem_in  = t0;
         dv_in   = dv_ff >> 2;
         quo_in  = (quo_ff << 2) | QP'({b1, b0});
         cnt_in  = SCW'(cnt_ff + SCW'(1));
         done_in = (cnt_ff == SCW'(STEPS - 1));
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in  = s2_valid_ff;
      s2_mode_in   = s2_mode_ff;
      s2_ok_in     = s2_ok_ff;
      s2_row_in    = s2_row_ff;
      s2_col_in    = s2_col_ff;
      s2_centre_in = s2_centre_ff;
      if (s2_load) begin
         s2_valid_in  = 1'b1;
         s2_mode_in   = s1_ff.mode;
         s2_centre_in = s1_ff.centre_cell;
         if (s1_ff.mode == MODE_BIN) begin
            s2_ok_in  = bin_ok;
            s2_row_in = RW'($unsigned(row_s));
            s2_col_in = CW'($unsigned(col_s));
         end else begin
            s2_ok_in  = centre_in;
            s2_row_in = RW'(quo_ff);
            s2_col_in = CW'(rem_ff);
         end
      end else if (wq_push) begin
         s2_valid_in = 1'b0;
      end
   end

   // Queue entry: binned index, or the valid slots around the centre.
   logic [PRW-1:0]        prod;
   logic [IDX_W-1:0]      bin_idx;
   logic                  r_lo, r_hi, c_lo, c_hi;
   logic [SLOT_COUNT-1:0] all_mask;

   always_comb begin
      prod     = PRW'(s2_row_ff) * PRW'(cols_ff);
      bin_idx  = IDX_W'(prod + PRW'(s2_col_ff));
      r_lo     = s2_row_ff != '0;
      r_hi     = ((RW + 1)'(s2_row_ff) + (RW + 1)'(1)) < (RW + 1)'(rows_ff);
      c_lo     = s2_col_ff != '0;
      c_hi     = ((CW + 1)'(s2_col_ff) + (CW + 1)'(1)) < (CW + 1)'(cols_ff);
      all_mask = nbr_mask(r_lo, r_hi, c_lo, c_hi);
      wq_push  = s2_valid_ff && !wq_full;

      wq_data.base    = '0;
      wq_data.in_grid = 1'b0;
      wq_data.mask    = SELF_ONLY;
      if (s2_ok_ff) begin
         wq_data.in_grid = 1'b1;
         unique case (s2_mode_ff)
            MODE_FWD: begin
               wq_data.base = s2_centre_ff;
               wq_data.mask = all_mask & FWD_SLOTS;
            end
            MODE_ALL: begin
               wq_data.base = s2_centre_ff;
               wq_data.mask = all_mask;
            end
            default: begin
               wq_data.base = bin_idx;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cols_ff      <= cols_c;
      rows_ff      <= rows_c;
      area_ff      <= area_in;
      if (accept) begin
         s1_ff <= req_data;
      end
      rem_ff       <= rem_in;
      dv_ff        <= dv_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      s2_mode_ff   <= s2_mode_in;
      s2_ok_ff     <= s2_ok_in;
      s2_row_ff    <= s2_row_in;
      s2_col_ff    <= s2_col_in;
      s2_centre_ff <= s2_centre_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         done_ff     <= done_in;
      end
   end

endmodule

### src/gcbn_queue.sv
// Short register queue that decouples the front end from the back end.
// Depends on gcbn_pkg for the entry type.
module gcbn_queue #(
   parameter int DEPTH = gcbn_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enq,
   input  gcbn_pkg::work_type enq_data,
   output logic               full,
   input  logic               deq,
   output gcbn_pkg::work_type deq_data,
   output logic               empty
);
   import gcbn_pkg::*;

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   work_type       slot_ff [DEPTH];
   logic [AW-1:0]  wptr_ff, wptr_in;
   logic [AW-1:0]  rptr_ff, rptr_in;
   logic [CNW-1:0] count_ff, count_in;
   logic           do_enq, do_deq;

   always_comb begin
      full     = count_ff == CNW'(DEPTH);
      empty    = count_ff == '0;
      do_enq   = enq && !full;
      do_deq   = deq && !empty;
      deq_data = slot_ff[rptr_ff];

      wptr_in = wptr_ff;
      if (do_enq) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wptr_ff + AW'(1));
      end
      rptr_in = rptr_ff;
      if (do_deq) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(rptr_ff + AW'(1));
      end
      count_in = count_ff;
      if (do_enq && !do_deq) begin
         count_in = CNW'(count_ff + CNW'(1));
      end else if (do_deq && !do_enq) begin
         count_in = CNW'(count_ff - CNW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         slot_ff[wptr_ff] <= enq_data;
      end
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### src/gcbn_back.sv
// Back end: walks the valid neighbour slots of one queued entry into the
// output register, one result a cycle unless stalled. Depends on gcbn_pkg.
module gcbn_back #(
   parameter int MAX_COLUMNS = gcbn_pkg::DEF_MAX_COLUMNS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [$clog2(MAX_COLUMNS + 1)-1:0] cols_eff,
   input  logic                               wq_empty,
   input  gcbn_pkg::work_type                 wq_data,
   output logic                               wq_pop,
   output gcbn_pkg::rsp_type                  rsp_data,
   output logic                               empty,
   input  logic                               pop
);
   import gcbn_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS + 1);
   localparam int SW = ((IDX_W > CW) ? IDX_W : CW) + 2;

   logic     cur_valid_ff, cur_valid_in;
   work_type cur_ff, cur_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;

   logic [SLOT_COUNT-1:0] onehot, rest;
   logic                  dr_neg, dr_pos, dc_neg, dc_pos;
   logic [SW-1:0]         row_off, col_off, sum;
   logic                  emit, last;

   always_comb begin
      onehot = cur_ff.mask & (~cur_ff.mask + SLOT_COUNT'(1));
      rest   = cur_ff.mask & ~onehot;
      last   = rest == '0;
      // Slot layout: three rows of three, row below first.
      dr_neg = |onehot[2:0];
      dr_pos = |onehot[8:6];
      dc_neg = onehot[0] | onehot[3] | onehot[6];
      dc_pos = onehot[2] | onehot[5] | onehot[8];
      row_off = dr_pos ? SW'(cols_eff) : (dr_neg ? (~SW'(cols_eff) + SW'(1)) : '0);
      col_off = dc_pos ? SW'(1) : (dc_neg ? '1 : '0);
      sum     = SW'(cur_ff.base) + row_off + col_off;

      emit   = cur_valid_ff && (!rsp_valid_ff || pop);
      wq_pop = !wq_empty && (!cur_valid_ff || (emit && last));

      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (wq_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = wq_data;
      end else if (emit) begin
         cur_valid_in = !last;
         cur_in.mask  = rest;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.cell_index = IDX_W'(sum);
         rsp_in.in_grid    = cur_ff.in_grid;
         rsp_in.is_last    = last;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/grid_cell_binning_and_neighbours.sv
// Top level of the uniform grid cell binning and neighbour generator.
// Holds the configuration registers; depends on gcbn_pkg, gcbn_front,
// gcbn_queue and gcbn_back.
//
// Usage. Requests enter through a queue-like port: a request is taken at a
// rising edge with push high and full low. Mode 0 bins a position into its
// row-major cell, mode 1 lists the forward half-neighbourhood of a cell and
// mode 2 its whole 3x3 block; mode 3 requests are dropped without a result.
// Results leave the same way: the oldest waiting result sits on rsp_data
// while empty is low and is taken at an edge with pop high. The last result
// of each request carries is_last.
// A request passes the input stage, the classified stage, the queue and the
// back end's current entry before its results reach the output register; in
// modes 1 and 2 the divider first splits the centre cell into row and column
// at two quotient bits a cycle. Mode 0 requests are taken every cycle while
// results are popped. A neighbour request holds the input stage until its
// division is done, and the back end gives one result a cycle while results
// are popped, up to 9 per request in mode 2 and 5 in mode 1. The two halves
// meet in a two-entry queue, so each can stall on its own. When pop is held
// low the output register, the queue and then the input stage fill in turn
// and full rises; nothing is lost. Reset is synchronous and active high: it
// empties every stage and returns the registers to a 64 by 64 grid at the
// origin with a cell shift of 8. Registers are written through csr_we,
// csr_index and csr_wdata; the user must do so only while the block is idle,
// as the block does not enforce it. Writes to unused indices are ignored.
module grid_cell_binning_and_neighbours #(
   parameter int MAX_COLUMNS = gcbn_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = gcbn_pkg::DEF_MAX_ROWS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  gcbn_pkg::req_type                  req_data,
   output logic                               empty,
   input  logic                               pop,
   output gcbn_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [gcbn_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gcbn_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gcbn_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS + 1);

   cfg_type cfg_ff, cfg_in;

   // Configuration writes take effect at the next edge.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_COLUMNS:    cfg_in.grid_columns = csr_wdata[SIZE_W-1:0];
            REG_ROWS:       cfg_in.grid_rows    = csr_wdata[SIZE_W-1:0];
            REG_ORIGIN_X:   cfg_in.origin_x     = csr_wdata[POS_W-1:0];
            REG_ORIGIN_Y:   cfg_in.origin_y     = csr_wdata[POS_W-1:0];
            REG_CELL_SHIFT: cfg_in.cell_shift   = csr_wdata[SHIFT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_columns <= RST_COLUMNS;
         cfg_ff.grid_rows    <= RST_ROWS;
         cfg_ff.origin_x     <= '0;
         cfg_ff.origin_y     <= '0;
         cfg_ff.cell_shift   <= RST_SHIFT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   logic          wq_push, wq_full, wq_pop, wq_empty;
   work_type      wq_in_data, wq_out_data;
   logic [CW-1:0] cols_eff;

   // The front end classifies each request and resolves row and column.
   gcbn_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .wq_full  (wq_full),
      .wq_push  (wq_push),
      .wq_data  (wq_in_data),
      .cols_eff (cols_eff)
   );

   gcbn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (wq_push),
      .enq_data (wq_in_data),
      .full     (wq_full),
      .deq      (wq_pop),
      .deq_data (wq_out_data),
      .empty    (wq_empty)
   );

   // The back end expands each entry into results, one per unstalled cycle.
   gcbn_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cols_eff (cols_eff),
      .wq_empty (wq_empty),
      .wq_data  (wq_out_data),
      .wq_pop   (wq_pop),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

endmodule
